>>> design/sfrs_pkg.sv
// ----------------------------------------------------------------------------
// sfrs_pkg
// Shared types, register indexes, result kinds, phase codes and the
// constant-divisor helpers of the stick frame radio sequencer.
// ----------------------------------------------------------------------------
package sfrs_pkg;

   localparam int DIFF_BITS = 17;
   localparam int MAG_BITS  = 16;

   // configuration register indexes
   localparam logic [2:0] REG_STICK_UPPER = 3'd0;
   localparam logic [2:0] REG_STICK_LOWER = 3'd1;
   localparam logic [2:0] REG_YAW_UPPER   = 3'd2;
   localparam logic [2:0] REG_YAW_LOWER   = 3'd3;
   localparam logic [2:0] REG_TRIM_CENTER = 3'd4;

   localparam logic [11:0] RST_STICK_UPPER = 12'd2348;
   localparam logic [11:0] RST_STICK_LOWER = 12'd1748;
   localparam logic [11:0] RST_YAW_UPPER   = 12'd2148;
   localparam logic [11:0] RST_YAW_LOWER   = 12'd1948;
   localparam logic [11:0] RST_TRIM_CENTER = 12'd2048;

   // result kinds
   localparam logic [1:0] KIND_FRAME = 2'd0;
   localparam logic [1:0] KIND_RX    = 2'd1;
   localparam logic [1:0] KIND_TX    = 2'd2;
   localparam logic [1:0] KIND_TELEM = 2'd3;

   // phase codes
   localparam logic [2:0] PHASE_IDLE   = 3'd0;
   localparam logic [2:0] PHASE_CMD_A  = 3'd1;
   localparam logic [2:0] PHASE_CMD_B  = 3'd2;
   localparam logic [2:0] PHASE_CMD_L  = 3'd3;
   localparam logic [2:0] PHASE_TO_RX  = 3'd4;
   localparam logic [2:0] PHASE_TLM_A  = 3'd5;
   localparam logic [2:0] PHASE_TLM_B  = 3'd6;
   localparam logic [2:0] PHASE_TO_TX  = 3'd7;

   // telemetry header bytes
   localparam logic [7:0] HEAD_BYTE0 = 8'h1A;
   localparam logic [7:0] HEAD_BYTE1 = 8'h0C;

   // reciprocal multipliers, exact for magnitudes below 2**16
   localparam logic [16:0] STICK_DIV_MUL   = 17'd119838;   // divide by 70
   localparam logic [4:0]  STICK_DIV_SHIFT = 5'd23;
   localparam logic [16:0] TRIM_DIV_MUL    = 17'd83887;    // divide by 400
   localparam logic [4:0]  TRIM_DIV_SHIFT  = 5'd25;
   localparam logic [16:0] YAW_DIV_MUL     = 17'd69906;    // divide by 15
   localparam logic [4:0]  YAW_DIV_SHIFT   = 5'd20;

   typedef struct packed {
      logic [1:0]         kind;
      logic [11:0]        frame_throttle;
      logic signed [15:0] frame_yaw;
      logic signed [7:0]  frame_roll;
      logic signed [7:0]  frame_pitch;
      logic [7:0]         frame_tumble;
      logic               listen_notice;
      logic [15:0]        battery_word;
      logic [6:0]         battery_slot;
      logic               battery_stored;
      logic               last;
   } result_type;

   typedef struct packed {
      logic valid;
      logic two;
   } load_type;

   // signed quotient truncated toward zero, divisor given by its reciprocal
   function automatic logic signed [DIFF_BITS-1:0] sdiv_const(
      input logic signed [DIFF_BITS-1:0] d,
      input logic [16:0]                 mul,
      input logic [4:0]                  shift);
      logic [MAG_BITS-1:0] mag;
      logic [32:0]         prod;
      logic [MAG_BITS-1:0] quo;
      mag  = d[DIFF_BITS-1] ? MAG_BITS'(-d) : d[MAG_BITS-1:0];
      prod = 33'(mag) * 33'(mul);
      quo  = MAG_BITS'(prod >> shift);
      return d[DIFF_BITS-1] ? -DIFF_BITS'(quo) : DIFF_BITS'(quo);
   endfunction

endpackage

>>> design/stick_frame_radio_sequencer_unit.sv
// ----------------------------------------------------------------------------
// stick_frame_radio_sequencer_unit
// Turns stick samples into command frames and steps a seven-phase radio
// cycle of frames, radio mode switches and telemetry results.
//
//  channel  | dir | handshake             | payload
//  ---------+-----+-----------------------+-------------------------------
//  req_     | in  | req_valid / req_stall | stick samples, trims, header
//  rsp_     | out | rsp_valid / rsp_stall | kind, frame, battery, last
//  csr_     | in  | csr_write_enable      | csr_index, csr_data
//
// A request is held in the input register until the result register can take
// it; its one or two results are then loaded into the result register.
// Requests that cause two results (phases four and seven) hold the result
// register until both results are taken.
// A new request is taken each cycle while the result side keeps up and no pair is held.
// Synchronous reset clears phase, slot, valid flags and config registers to
// their defaults; rsp_stall backs up through req_stall the same cycle.
// ----------------------------------------------------------------------------
module stick_frame_radio_sequencer_unit #(
   parameter int TELEMETRY_SLOTS = 100,
   parameter int SAMPLE_BITS     = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [SAMPLE_BITS-1:0] req_throttle_level,
   input  logic [SAMPLE_BITS-1:0] req_yaw_stick,
   input  logic [SAMPLE_BITS-1:0] req_roll_trim,
   input  logic [SAMPLE_BITS-1:0] req_pitch_trim,
   input  logic [SAMPLE_BITS-1:0] req_roll_stick,
   input  logic [SAMPLE_BITS-1:0] req_pitch_stick,
   input  logic signed [15:0]     req_yaw_offset,
   input  logic [7:0]             req_tumble_mode,
   input  logic [31:0]            req_reply_head,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [1:0]             rsp_kind,
   output logic [11:0]            rsp_frame_throttle,
   output logic signed [15:0]     rsp_frame_yaw,
   output logic signed [7:0]      rsp_frame_roll,
   output logic signed [7:0]      rsp_frame_pitch,
   output logic [7:0]             rsp_frame_tumble,
   output logic                   rsp_listen_notice,
   output logic [15:0]            rsp_battery_word,
   output logic [6:0]             rsp_battery_slot,
   output logic                   rsp_battery_stored,
   output logic                   rsp_last,
   input  logic                   csr_write_enable,
   input  logic [2:0]             csr_index,
   input  logic [11:0]            csr_data
);

   logic [11:0] stick_upper_ff, stick_lower_ff, yaw_upper_ff, yaw_lower_ff;
   logic [11:0] trim_center_ff;

   logic                   in_valid_ff, in_valid_in;
   logic [SAMPLE_BITS-1:0] throttle_ff, yaw_stick_ff, roll_trim_ff, pitch_trim_ff;
   logic [SAMPLE_BITS-1:0] roll_stick_ff, pitch_stick_ff;
   logic signed [15:0]     yaw_offset_ff;
   logic [7:0]             tumble_ff;
   logic [31:0]            head_ff;

   logic [2:0] phase_ff, phase_in;
   logic [6:0] slot_ff, slot_in;

   logic                 accept;
   logic                 advance;
   logic                 can_load;
   logic [2:0]           phase_step;
   logic [7:0]           slot_sum;
   logic [15:0]          throttle_ext;
   logic signed [15:0]   yaw_cmd;
   logic signed [7:0]    roll_cmd;
   logic signed [7:0]    pitch_cmd;
   sfrs_pkg::result_type frame_res, telem_res, mode_res;
   sfrs_pkg::result_type first_res, second_res, rsp_result;
   sfrs_pkg::load_type   load;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         stick_upper_ff <= sfrs_pkg::RST_STICK_UPPER;
         stick_lower_ff <= sfrs_pkg::RST_STICK_LOWER;
         yaw_upper_ff   <= sfrs_pkg::RST_YAW_UPPER;
         yaw_lower_ff   <= sfrs_pkg::RST_YAW_LOWER;
         trim_center_ff <= sfrs_pkg::RST_TRIM_CENTER;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            sfrs_pkg::REG_STICK_UPPER: stick_upper_ff <= csr_data;
            sfrs_pkg::REG_STICK_LOWER: stick_lower_ff <= csr_data;
            sfrs_pkg::REG_YAW_UPPER:   yaw_upper_ff   <= csr_data;
            sfrs_pkg::REG_YAW_LOWER:   yaw_lower_ff   <= csr_data;
            sfrs_pkg::REG_TRIM_CENTER: trim_center_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // input register
   assign advance     = in_valid_ff && can_load;
   assign req_stall   = in_valid_ff && !can_load;
   assign accept      = req_valid && !req_stall;
   assign in_valid_in = accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (accept) begin
         throttle_ff    <= req_throttle_level;
         yaw_stick_ff   <= req_yaw_stick;
         roll_trim_ff   <= req_roll_trim;
         pitch_trim_ff  <= req_pitch_trim;
         roll_stick_ff  <= req_roll_stick;
         pitch_stick_ff <= req_pitch_stick;
         yaw_offset_ff  <= req_yaw_offset;
         tumble_ff      <= req_tumble_mode;
         head_ff        <= req_reply_head;
      end
   end

   // command math
   sfrs_axis u_roll (
      .stick       (16'(roll_stick_ff)),
      .trim        (16'(roll_trim_ff)),
      .upper_edge  (stick_upper_ff),
      .lower_edge  (stick_lower_ff),
      .trim_center (trim_center_ff),
      .command     (roll_cmd)
   );

   sfrs_axis u_pitch (
      .stick       (16'(pitch_stick_ff)),
      .trim        (16'(pitch_trim_ff)),
      .upper_edge  (stick_upper_ff),
      .lower_edge  (stick_lower_ff),
      .trim_center (trim_center_ff),
      .command     (pitch_cmd)
   );

   sfrs_yaw u_yaw (
      .stick      (16'(yaw_stick_ff)),
      .offset     (yaw_offset_ff),
      .upper_edge (yaw_upper_ff),
      .lower_edge (yaw_lower_ff),
      .command    (yaw_cmd)
   );

   // phase sequencing and result build
   always_comb begin
      throttle_ext = 16'(throttle_ff);
      phase_step   = phase_ff + 3'd1;
      slot_sum     = 8'(slot_ff) + 8'd1;

      frame_res                = '0;
      frame_res.kind           = sfrs_pkg::KIND_FRAME;
      frame_res.frame_throttle = throttle_ext[11:0];
      frame_res.frame_yaw      = yaw_cmd;
      frame_res.frame_roll     = roll_cmd;
      frame_res.frame_pitch    = pitch_cmd;
      frame_res.frame_tumble   = tumble_ff;

      telem_res                = '0;
      telem_res.kind           = sfrs_pkg::KIND_TELEM;
      telem_res.battery_word   = head_ff[15:0];
      telem_res.battery_slot   = slot_ff;
      telem_res.battery_stored = (head_ff[31:24] == sfrs_pkg::HEAD_BYTE0) &&
                                 (head_ff[23:16] == sfrs_pkg::HEAD_BYTE1);
      telem_res.last           = 1'b1;

      mode_res   = '0;
      first_res  = frame_res;
      second_res = '0;
      load.valid = advance;
      load.two   = 1'b0;
      phase_in   = phase_step;
      slot_in    = slot_ff;

      unique case (phase_step)
         sfrs_pkg::PHASE_CMD_A, sfrs_pkg::PHASE_CMD_B: begin
            first_res.last = 1'b1;
         end
         sfrs_pkg::PHASE_CMD_L: begin
            first_res.listen_notice = 1'b1;
            first_res.last          = 1'b1;
         end
         sfrs_pkg::PHASE_TO_RX: begin
            first_res.listen_notice = 1'b1;
            mode_res.kind           = sfrs_pkg::KIND_RX;
            mode_res.last           = 1'b1;
            second_res              = mode_res;
            load.two                = 1'b1;
         end
         sfrs_pkg::PHASE_TLM_A, sfrs_pkg::PHASE_TLM_B: begin
            first_res = telem_res;
            slot_in   = slot_sum[6:0];
            if (8'(slot_sum[6:0]) >= 8'(TELEMETRY_SLOTS)) begin
               slot_in = 7'd0;
            end
         end
         default: begin
            mode_res.kind   = sfrs_pkg::KIND_TX;
            first_res       = mode_res;
            second_res      = frame_res;
            second_res.last = 1'b1;
            load.two        = 1'b1;
            phase_in        = sfrs_pkg::PHASE_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= sfrs_pkg::PHASE_IDLE;
         slot_ff  <= 7'd0;
      end else if (advance) begin
         phase_ff <= phase_in;
         slot_ff  <= slot_in;
      end
   end

   sfrs_out_buf u_out_buf (
      .clock         (clock),
      .reset         (reset),
      .load          (load),
      .first_result  (first_res),
      .second_result (second_res),
      .can_load      (can_load),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_result    (rsp_result)
   );

   assign rsp_kind           = rsp_result.kind;
   assign rsp_frame_throttle = rsp_result.frame_throttle;
   assign rsp_frame_yaw      = rsp_result.frame_yaw;
   assign rsp_frame_roll     = rsp_result.frame_roll;
   assign rsp_frame_pitch    = rsp_result.frame_pitch;
   assign rsp_frame_tumble   = rsp_result.frame_tumble;
   assign rsp_listen_notice  = rsp_result.listen_notice;
   assign rsp_battery_word   = rsp_result.battery_word;
   assign rsp_battery_slot   = rsp_result.battery_slot;
   assign rsp_battery_stored = rsp_result.battery_stored;
   assign rsp_last           = rsp_result.last;

   a_phase_never_seven: assert property (@(posedge clock) disable iff (reset)
      phase_ff != sfrs_pkg::PHASE_TO_TX)
      else $error("phase register holds the transmit phase");

   a_slot_in_ring: assert property (@(posedge clock) disable iff (reset)
      8'(slot_ff) < 8'(TELEMETRY_SLOTS))
      else $error("telemetry slot outside ring");

   a_advance_shows_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("request moved on without a result");

endmodule

>>> design/sfrs_axis.sv
// ----------------------------------------------------------------------------
// sfrs_axis
// Roll or pitch command: stick deadband over 70 plus trim offset over 400.
// ----------------------------------------------------------------------------
module sfrs_axis (
   input  logic [15:0]       stick,
   input  logic [15:0]       trim,
   input  logic [11:0]       upper_edge,
   input  logic [11:0]       lower_edge,
   input  logic [11:0]       trim_center,
   output logic signed [7:0] command
);

   logic signed [16:0] diff_upper;
   logic signed [16:0] diff_lower;
   logic signed [16:0] diff_trim;
   logic signed [16:0] stick_term;
   logic signed [16:0] trim_term;
   logic signed [16:0] sum;

   always_comb begin
      diff_upper = 17'(stick) - 17'(upper_edge);
      diff_lower = 17'(stick) - 17'(lower_edge);
      diff_trim  = 17'(trim_center) - 17'(trim);
      trim_term  = sfrs_pkg::sdiv_const(diff_trim, sfrs_pkg::TRIM_DIV_MUL,
                                        sfrs_pkg::TRIM_DIV_SHIFT);
      priority if (!diff_upper[16]) begin
         stick_term = sfrs_pkg::sdiv_const(diff_upper, sfrs_pkg::STICK_DIV_MUL,
                                           sfrs_pkg::STICK_DIV_SHIFT);
      end else if (diff_lower[16] || (diff_lower == 17'sd0)) begin
         stick_term = sfrs_pkg::sdiv_const(diff_lower, sfrs_pkg::STICK_DIV_MUL,
                                           sfrs_pkg::STICK_DIV_SHIFT);
      end else begin
         stick_term = 17'sd0;
      end
      sum     = stick_term + trim_term;
      command = sum[7:0];
   end

endmodule

>>> design/sfrs_yaw.sv
// ----------------------------------------------------------------------------
// sfrs_yaw
// Yaw command: deadband over 15 plus signed trim, saturated to 16 bits.
// ----------------------------------------------------------------------------
module sfrs_yaw (
   input  logic [15:0]        stick,
   input  logic signed [15:0] offset,
   input  logic [11:0]        upper_edge,
   input  logic [11:0]        lower_edge,
   output logic signed [15:0] command
);

   logic signed [16:0] diff_upper;
   logic signed [16:0] diff_lower;
   logic signed [16:0] stick_term;
   logic signed [17:0] sum;

   always_comb begin
      diff_upper = 17'(stick) - 17'(upper_edge);
      diff_lower = 17'(stick) - 17'(lower_edge);
      priority if (!diff_upper[16]) begin
         stick_term = sfrs_pkg::sdiv_const(diff_upper, sfrs_pkg::YAW_DIV_MUL,
                                           sfrs_pkg::YAW_DIV_SHIFT);
      end else if (diff_lower[16] || (diff_lower == 17'sd0)) begin
         stick_term = sfrs_pkg::sdiv_const(diff_lower, sfrs_pkg::YAW_DIV_MUL,
                                           sfrs_pkg::YAW_DIV_SHIFT);
      end else begin
         stick_term = 17'sd0;
      end
      sum = {stick_term[16], stick_term} + {{2{offset[15]}}, offset};
      priority if (sum > 18'sd32767) begin
         command = 16'sh7FFF;
      end else if (sum < -18'sd32768) begin
         command = 16'sh8000;
      end else begin
         command = sum[15:0];
      end
   end

endmodule

>>> design/sfrs_out_buf.sv
// ----------------------------------------------------------------------------
// sfrs_out_buf
// Result register holding up to two results of one request; shows them in
// order and frees itself after the last one is taken.
// ----------------------------------------------------------------------------
module sfrs_out_buf (
   input  logic                   clock,
   input  logic                   reset,
   input  sfrs_pkg::load_type     load,
   input  sfrs_pkg::result_type   first_result,
   input  sfrs_pkg::result_type   second_result,
   output logic                   can_load,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output sfrs_pkg::result_type   rsp_result
);

   logic                 valid_ff, valid_in;
   logic                 two_ff, two_in;
   logic                 second_ff, second_in;
   sfrs_pkg::result_type res0_ff, res0_in;
   sfrs_pkg::result_type res1_ff, res1_in;
   logic                 take;
   logic                 on_last;

   always_comb begin
      take     = valid_ff && !rsp_stall;
      on_last  = !two_ff || second_ff;
      can_load = !valid_ff || (take && on_last);
      valid_in  = valid_ff;
      two_in    = two_ff;
      second_in = second_ff;
      res0_in   = res0_ff;
      res1_in   = res1_ff;
      priority if (load.valid && can_load) begin
         valid_in  = 1'b1;
         two_in    = load.two;
         second_in = 1'b0;
         res0_in   = first_result;
         res1_in   = second_result;
      end else if (take && !on_last) begin
         second_in = 1'b1;
      end else if (take) begin
         valid_in  = 1'b0;
         second_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         two_ff    <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         two_ff    <= two_in;
         second_ff <= second_in;
      end
      res0_ff <= res0_in;
      res1_ff <= res1_in;
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = second_ff ? res1_ff : res0_ff;

   a_second_needs_pair: assert property (@(posedge clock) disable iff (reset)
      second_ff |-> (valid_ff && two_ff))
      else $error("second result shown without a pair");

   a_first_not_last_of_pair: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && two_ff && !second_ff) |-> !res0_ff.last)
      else $error("first of a pair marked last");

endmodule
